/* rtl/ipc_pkg.sv */
// shared widths and parameter defaults for the integer partition counter
package ipc_pkg;

  // fixed field widths of the stream payloads
  localparam int TARGET_W    = 7;
  localparam int OUT_COUNT_W = 32;
  localparam int IN_TDATA_W  = 8;

  // defaults for the top level parameters
  localparam int DEF_MAX_TARGET  = 100;
  localparam int DEF_COUNT_WIDTH = 32;

endpackage

/* rtl/ipc_table.sv */
// count table: one write port, two registered read ports with write bypass
module ipc_table #(
  parameter int DEPTH  = 101,
  parameter int IDX_W  = 7,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [IDX_W-1:0]  rd_addr_a,
  input  logic [IDX_W-1:0]  rd_addr_b,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] ram_a;
  logic [DATA_W-1:0] ram_b;
  logic              byp_a;
  logic              byp_b;
  logic [DATA_W-1:0] byp_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    ram_a <= mem[rd_addr_a];
    ram_b <= mem[rd_addr_b];
  end

  // a read in the same cycle as a write to that entry sees the new value
  always_ff @(posedge clk) begin
    byp_a    <= wr_en && (wr_addr == rd_addr_a);
    byp_b    <= wr_en && (wr_addr == rd_addr_b);
    byp_data <= wr_data;
  end

  assign rd_data_a = byp_a ? byp_data : ram_a;
  assign rd_data_b = byp_b ? byp_data : ram_b;

endmodule

/* rtl/ipc_seq.sv */
// request sequencer: clear pass, read-add-write sweep, result fetch
module ipc_seq
  import ipc_pkg::*;
#(
  parameter int MAX_TARGET  = DEF_MAX_TARGET,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
  parameter int IDX_W       = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [TARGET_W-1:0]    target,
  output logic                   idle,
  output logic                   tbl_wr_en,
  output logic [IDX_W-1:0]       tbl_wr_addr,
  output logic [COUNT_WIDTH-1:0] tbl_wr_data,
  output logic [IDX_W-1:0]       tbl_rd_addr_a,
  output logic [IDX_W-1:0]       tbl_rd_addr_b,
  input  logic [COUNT_WIDTH-1:0] tbl_rd_data_a,
  input  logic [COUNT_WIDTH-1:0] tbl_rd_data_b,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [COUNT_WIDTH-1:0] res_count,
  output logic                   res_ovf
);

  localparam int CMP_W = (IDX_W > TARGET_W) ? IDX_W : TARGET_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_UPDATE,
    S_FETCH,
    S_CAPTURE,
    S_DONE
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     t;
  logic [IDX_W-1:0]     i;
  logic [IDX_W-1:0]     j;
  logic [IDX_W-1:0]     wj;
  logic                 upd_valid;
  logic                 ovf;
  logic [COUNT_WIDTH:0] sum;
  logic                 sum_carry;
  logic                 too_big;

  assign too_big = CMP_W'(target) > CMP_W'(MAX_TARGET);

  // saturating add of the two table reads
  assign sum       = {1'b0, tbl_rd_data_a} + {1'b0, tbl_rd_data_b};
  assign sum_carry = sum[COUNT_WIDTH];

  always_comb begin
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = j;
    tbl_wr_data = '0;
    if (state == S_CLEAR) begin
      tbl_wr_en   = 1'b1;
      tbl_wr_data = (j == '0) ? COUNT_WIDTH'(1) : '0;
    end else if (upd_valid) begin
      tbl_wr_en   = 1'b1;
      tbl_wr_addr = wj;
      tbl_wr_data = sum_carry ? '1 : sum[COUNT_WIDTH-1:0];
    end
    tbl_rd_addr_a = (state == S_FETCH) ? t : j;
    tbl_rd_addr_b = j - i;
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      upd_valid <= 1'b0;
      ovf       <= 1'b0;
      t         <= '0;
      i         <= '0;
      j         <= '0;
    end else begin
      upd_valid <= (state == S_UPDATE);
      wj        <= j;
      if (upd_valid && sum_carry) begin
        ovf <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (too_big) begin
              res_count <= '1;
              res_ovf   <= 1'b1;
              state     <= S_DONE;
            end else begin
              t     <= IDX_W'(target);
              j     <= '0;
              ovf   <= 1'b0;
              state <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          if (j == t) begin
            i     <= IDX_W'(1);
            j     <= IDX_W'(1);
            state <= (t == '0) ? S_FETCH : S_UPDATE;
          end else begin
            j <= j + IDX_W'(1);
          end
        end
        S_UPDATE: begin
          if (j == t) begin
            if (i == t) begin
              state <= S_FETCH;
            end else begin
              i <= i + IDX_W'(1);
              j <= i + IDX_W'(1);
            end
          end else begin
            j <= j + IDX_W'(1);
          end
        end
        S_FETCH: begin
          state <= S_CAPTURE;
        end
        S_CAPTURE: begin
          res_count <= tbl_rd_data_a;
          res_ovf   <= ovf;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/integer_partition_counter_core.sv */
// top level of the integer partition counter
//
// usage:
//   s_* channel: one transaction carries a target n (0..MAX_TARGET) and starts
//   one request. m_* channel: one transaction per request returns p(n), the
//   number of unordered ways to write n as a sum of positive integers, with
//   an overflow flag in tuser when a sum saturated at COUNT_WIDTH bits.
// operation:
//   a request runs a clear pass over entries 0..n, then one table
//   read-add-write per cycle for n(n+1)/2 updates, then a fetch of the
//   final entry. the sweep is bound by the single write port of the table.
//   a target above MAX_TARGET returns the saturated count without a sweep.
//   one request is worked on at a time; s_tready is high only between them.
// reset and stalls:
//   rst clears the sequencer state and the output valid; the table itself is
//   not cleared, each request clears the entries it uses. the result sits in
//   an output register, so a new target is taken while m_tready is low; the
//   next result waits in the sequencer until the output register frees up.
module integer_partition_counter_core
  import ipc_pkg::*;
#(
  parameter int MAX_TARGET  = DEF_MAX_TARGET,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [6:0] target, [7] zero
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_COUNT_W-1:0] m_tdata,   // [31:0] partition_count
  output logic                   m_tuser    // [0] overflowed
);

  localparam int IDX_W = (MAX_TARGET > 1) ? $clog2(MAX_TARGET + 1) : 1;
  localparam int DEPTH = MAX_TARGET + 1;

  // table port wires
  logic                   tbl_wr_en;
  logic [IDX_W-1:0]       tbl_wr_addr;
  logic [COUNT_WIDTH-1:0] tbl_wr_data;
  logic [IDX_W-1:0]       tbl_rd_addr_a;
  logic [IDX_W-1:0]       tbl_rd_addr_b;
  logic [COUNT_WIDTH-1:0] tbl_rd_data_a;
  logic [COUNT_WIDTH-1:0] tbl_rd_data_b;

  // sequencer result handshake
  logic                   seq_idle;
  logic                   res_valid;
  logic                   res_ready;
  logic [COUNT_WIDTH-1:0] res_count;
  logic                   res_ovf;
  logic                   in_xfer;

  assign s_tready = seq_idle;
  assign in_xfer  = s_tvalid && s_tready;

  // output register frees up in the same cycle it is drained
  assign res_ready = !m_tvalid || m_tready;

  ipc_seq #(
    .MAX_TARGET  (MAX_TARGET),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (in_xfer),
    .target        (s_tdata[TARGET_W-1:0]),
    .idle          (seq_idle),
    .tbl_wr_en     (tbl_wr_en),
    .tbl_wr_addr   (tbl_wr_addr),
    .tbl_wr_data   (tbl_wr_data),
    .tbl_rd_addr_a (tbl_rd_addr_a),
    .tbl_rd_addr_b (tbl_rd_addr_b),
    .tbl_rd_data_a (tbl_rd_data_a),
    .tbl_rd_data_b (tbl_rd_data_b),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_count     (res_count),
    .res_ovf       (res_ovf)
  );

  ipc_table #(
    .DEPTH  (DEPTH),
    .IDX_W  (IDX_W),
    .DATA_W (COUNT_WIDTH)
  ) u_table (
    .clk       (clk),
    .wr_en     (tbl_wr_en),
    .wr_addr   (tbl_wr_addr),
    .wr_data   (tbl_wr_data),
    .rd_addr_a (tbl_rd_addr_a),
    .rd_addr_b (tbl_rd_addr_b),
    .rd_data_a (tbl_rd_data_a),
    .rd_data_b (tbl_rd_data_b)
  );

  // output register, loaded when the sequencer hands over a result
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
      if (res_valid) begin
        m_tdata <= OUT_COUNT_W'(res_count);
        m_tuser <= res_ovf;
      end
    end
  end

  // a start takes the sequencer out of idle
  assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_tready)
    else $error("input accepted while a request was starting");

  // a pending result holds until the output register takes it
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_count) && $stable(res_ovf)))
    else $error("pending result changed before handover");

  // no table write while the sequencer waits for a new target
  assert property (@(posedge clk) disable iff (rst)
    (seq_idle && $past(seq_idle)) |-> !tbl_wr_en)
    else $error("table written while idle");

  // reset leaves no result on the output
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

/* test/tb.sv */
// partition counter core testbench: directed and random targets vs predictor or typed rows
`timescale 1ns / 1ps

module tb;
  import ipc_pkg::*;

  localparam int MAX_N   = DEF_MAX_TARGET;
  localparam int COUNT_W = DEF_COUNT_WIDTH;
  localparam int N_PHASES = 4;
  localparam int RANDOM_PER_PHASE = 24;
  localparam int N_DIRECTED = 16;
  localparam int DRAIN_CYCLES = 200;

  // one expected m_* transaction
  typedef struct packed {
    logic [OUT_COUNT_W-1:0] count;
    logic                   ovf;
  } partition_result_t;

  // directed stimulus row; typed rows carry their expected result
  typedef struct packed {
    logic [TARGET_W-1:0]    target;
    logic                   typed;
    logic [OUT_COUNT_W-1:0] count;
    logic                   ovf;
  } directed_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_COUNT_W-1:0] m_tdata;
  logic                   m_tuser;

  // predictor scratch table, one count per target
  logic [COUNT_W-1:0] count_tbl [0:MAX_N];

  partition_result_t pending_results[$];
  int unsigned       mismatch_cnt = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;

  // extremes, the zero target, targets past the table, both values of the top bit
  directed_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{7'd0,   1'b1, 32'd1,         1'b0},
    '{7'd1,   1'b1, 32'd1,         1'b0},
    '{7'd2,   1'b1, 32'd2,         1'b0},
    '{7'd3,   1'b0, 32'd0,         1'b0},
    '{7'd5,   1'b0, 32'd0,         1'b0},
    '{7'd100, 1'b1, 32'd190569292, 1'b0},
    '{7'd101, 1'b1, 32'hFFFF_FFFF, 1'b1},
    '{7'd127, 1'b1, 32'hFFFF_FFFF, 1'b1},
    '{7'd0,   1'b1, 32'd1,         1'b0},
    '{7'd64,  1'b0, 32'd0,         1'b0},
    '{7'd63,  1'b0, 32'd0,         1'b0},
    '{7'd10,  1'b0, 32'd0,         1'b0},
    '{7'd99,  1'b0, 32'd0,         1'b0},
    '{7'd120, 1'b1, 32'hFFFF_FFFF, 1'b1},
    '{7'd42,  1'b0, 32'd0,         1'b0},
    '{7'd7,   1'b0, 32'd0,         1'b0}
  };

  integer_partition_counter_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // coin-style sweep with saturating adds, sticky overflow per request
  function automatic partition_result_t count_partitions(input logic [TARGET_W-1:0] n);
    partition_result_t res;
    logic [COUNT_W:0]  sum;
    logic              ovf;
    int                i;
    int                j;
    ovf = 1'b0;
    if (n > MAX_N) begin
      res.count = OUT_COUNT_W'({COUNT_W{1'b1}});
      res.ovf   = 1'b1;
      return res;
    end
    for (j = 0; j <= n; j++) count_tbl[j] = '0;
    count_tbl[0] = COUNT_W'(1);
    for (i = 1; i <= n; i++) begin
      for (j = i; j <= n; j++) begin
        sum = {1'b0, count_tbl[j]} + {1'b0, count_tbl[j-i]};
        if (sum[COUNT_W]) begin
          count_tbl[j] = {COUNT_W{1'b1}};
          ovf = 1'b1;
        end else begin
          count_tbl[j] = sum[COUNT_W-1:0];
        end
      end
    end
    res.count = OUT_COUNT_W'(count_tbl[n]);
    res.ovf   = ovf;
    return res;
  endfunction

  // mostly small targets, a few large ones and some past the table
  function automatic logic [TARGET_W-1:0] pick_target();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return TARGET_W'($urandom_range(24));
    else if (r < 90) return TARGET_W'($urandom_range(60, 25));
    else if (r < 96) return TARGET_W'($urandom_range(MAX_N, 61));
    else return TARGET_W'($urandom_range(127, MAX_N + 1));
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // one s_* transaction; expectation is queued once it is accepted
  task automatic send_target(input logic [TARGET_W-1:0] t, input logic typed,
                             input logic [OUT_COUNT_W-1:0] cnt, input logic ovf);
    partition_result_t res;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, t};
    do @(posedge clk); while (!s_tready);
    res = count_partitions(t);
    if (typed) begin
      res.count = cnt;
      res.ovf   = ovf;
    end
    pending_results.push_back(res);
  endtask

  // receiver: random back-pressure and result checking
  always @(posedge clk) begin
    partition_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {32'd0, m_tdata}, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== want.count)
          report_mismatch("partition_count", {32'd0, m_tdata}, {32'd0, want.count});
        if (m_tuser !== want.ovf)
          report_mismatch("overflowed", {63'd0, m_tuser}, {63'd0, want.ovf});
      end
    end
    if (rst) m_tready <= 1'b0;
    else m_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  initial begin
    int unsigned idle_pct  [0:N_PHASES-1] = '{0, 74, 0, 17};
    int unsigned stall_pct [0:N_PHASES-1] = '{0, 0, 74, 17};
    int          ph;
    int          k;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (ph = 0; ph < N_PHASES; ph++) begin
      send_idle_pct  = idle_pct[ph];
      recv_stall_pct = stall_pct[ph];
      if (ph == 0) begin
        for (k = 0; k < N_DIRECTED; k++)
          send_target(directed_rows[k].target, directed_rows[k].typed,
                      directed_rows[k].count, directed_rows[k].ovf);
      end
      for (k = 0; k < RANDOM_PER_PHASE; k++)
        send_target(pick_target(), 1'b0, '0, 1'b0);
      // hold off until the block has returned everything so far
      s_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, well past the slowest legal run
  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
